@@ rtl/fme_pkg.sv @@
// package: types and constants for the fuzzy membership evaluator
package fme_pkg;

  localparam int IN_FRAC_BITS_DEF  = 16;
  localparam int OUT_FRAC_BITS_DEF = 15;
  localparam int POINT_W           = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int DIFF_W            = POINT_W + 1;

  typedef enum logic [1:0] {
    SHAPE_TRI   = 2'd0,
    SHAPE_TRAP  = 2'd1,
    SHAPE_RIGHT = 2'd2,
    SHAPE_LEFT  = 2'd3
  } shape_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE   = 3'd0,
    REG_POINT_A = 3'd1,
    REG_POINT_B = 3'd2,
    REG_POINT_C = 3'd3,
    REG_POINT_D = 3'd4
  } reg_idx_t;

  // ramp control after setup: sign handled, early outcomes known
  typedef struct packed {
    logic used;
    logic zero;
    logic one;
    logic deg;
  } ramp_ctl_t;

endpackage

@@ rtl/fme_ramp_setup.sv @@
// module: ramp setup, forms magnitude numerator and divisor of one ramp
module fme_ramp_setup (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        used,
  input  logic                        rising,
  input  logic signed [31:0]          x,
  input  logic signed [31:0]          p,
  input  logic signed [31:0]          q,
  output logic [32:0]                 num,
  output logic [32:0]                 den,
  output fme_pkg::ramp_ctl_t          ctl
);
  import fme_pkg::*;

  logic signed [DIFF_W:0] n_raw;
  logic signed [DIFF_W:0] d_raw;
  logic signed [DIFF_W:0] n_fix;
  logic signed [DIFF_W:0] d_fix;
  logic                   eq;
  logic                   step_one;
  ramp_ctl_t              ctl_next;

  // signed differences at full precision, then divisor made positive
  always_comb begin
    if (rising) begin
      n_raw = {{2{x[31]}}, x} - {{2{p[31]}}, p};
    end else begin
      n_raw = {{2{q[31]}}, q} - {{2{x[31]}}, x};
    end
    d_raw = {{2{q[31]}}, q} - {{2{p[31]}}, p};
    eq = (p == q);
    step_one = rising ? (x >= p) : (x <= q);
    if (d_raw[DIFF_W]) begin
      n_fix = -n_raw;
      d_fix = -d_raw;
    end else begin
      n_fix = n_raw;
      d_fix = d_raw;
    end
    ctl_next.used = used;
    ctl_next.deg  = used & eq;
    if (eq) begin
      ctl_next.one  = step_one;
      ctl_next.zero = !step_one;
    end else begin
      ctl_next.zero = (n_fix <= 0);
      ctl_next.one  = (n_fix > 0) && (n_fix >= d_fix);
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) begin
      num <= n_fix[32:0];
      den <= d_fix[32:0];
      ctl <= ctl_next;
    end
  end

endmodule

@@ rtl/fme_div_pipe.sv @@
// module: pipelined restoring divider, a few quotient bits per stage
module fme_div_pipe #(
  parameter int OUT_FRAC_BITS = fme_pkg::OUT_FRAC_BITS_DEF,
  parameter int BITS_PER_STAGE = 4
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [32:0]              num,
  input  logic [32:0]              den,
  output logic [OUT_FRAC_BITS-1:0] quo
);
  import fme_pkg::*;

  localparam int QB     = OUT_FRAC_BITS;
  localparam int STAGES = (QB + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int RW     = 34;

  // num < den here, so remainder stays below den and quotient has QB bits
  logic [RW-1:0] rem [STAGES+1];
  logic [32:0]   dv  [STAGES+1];
  logic [QB-1:0] qv  [STAGES+1];

  assign rem[0] = {1'b0, num};
  assign dv[0]  = den;
  assign qv[0]  = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [RW-1:0] r_c [BITS_PER_STAGE+1];
    logic [QB-1:0] q_c [BITS_PER_STAGE+1];
    always_comb begin
      r_c[0] = rem[s];
      q_c[0] = qv[s];
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        if (s * BITS_PER_STAGE + k < QB) begin
          if ({r_c[k][RW-2:0], 1'b0} >= {1'b0, dv[s]}) begin
            r_c[k+1] = {r_c[k][RW-2:0], 1'b0} - {1'b0, dv[s]};
            q_c[k+1] = {q_c[k][QB-2:0], 1'b1};
          end else begin
            r_c[k+1] = {r_c[k][RW-2:0], 1'b0};
            q_c[k+1] = {q_c[k][QB-2:0], 1'b0};
          end
        end else begin
          r_c[k+1] = r_c[k];
          q_c[k+1] = q_c[k];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= r_c[BITS_PER_STAGE];
        qv[s+1]  <= q_c[BITS_PER_STAGE];
        dv[s+1]  <= dv[s];
      end
    end
  end

  assign quo = qv[STAGES];

endmodule

@@ rtl/fuzzy_membership_evaluator.sv @@
// top level: fuzzy membership degree of one sample, pipelined
// path from start to done: ramp setup register, divider stages, output register
// throughput: one sample per cycle; busy is always low, no stalls exist
// the depth is set by the restoring divider, four quotient bits per stage
// reset: synchronous active-high rst clears valid bits and loads register defaults
// results appear on done for exactly one cycle; the receiver cannot stall
module fuzzy_membership_evaluator #(
  parameter int IN_FRAC_BITS  = fme_pkg::IN_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS = fme_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              sample_value,
  input  logic                            cfg_we,
  input  logic [fme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  output logic                            done,
  output logic [OUT_FRAC_BITS:0]          membership_degree,
  output logic                            degenerate_flag
);
  import fme_pkg::*;

  localparam int STAGES = (OUT_FRAC_BITS + 3) / 4;
  localparam int DEPTH  = STAGES + 2;
  localparam logic [OUT_FRAC_BITS:0] ONE_OUT = {1'b1, {OUT_FRAC_BITS{1'b0}}};

  // input scaling does not change the ratio
  localparam int InFracUnused = IN_FRAC_BITS;

  shape_t             shape;
  logic signed [31:0] point_a, point_b, point_c, point_d;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shape   <= SHAPE_TRI;
      point_a <= 32'sd0;
      point_b <= 32'sd65536;
      point_c <= 32'sd131072;
      point_d <= 32'sd196608;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPE:   shape   <= shape_t'(cfg_data[1:0]);
        REG_POINT_A: point_a <= cfg_data;
        REG_POINT_B: point_b <= cfg_data;
        REG_POINT_C: point_c <= cfg_data;
        REG_POINT_D: point_d <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid bits along the pipe
  logic [DEPTH-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], start};
    end
  end

  // pick breakpoints of each ramp
  logic               r_used, f_used;
  logic signed [31:0] r_p, r_q, f_p, f_q;
  always_comb begin
    r_p = point_a;
    r_q = point_b;
    f_p = point_a;
    f_q = point_b;
    r_used = 1'b1;
    f_used = 1'b1;
    case (shape)
      SHAPE_TRI: begin
        f_p = point_b;
        f_q = point_c;
      end
      SHAPE_TRAP: begin
        f_p = point_c;
        f_q = point_d;
      end
      SHAPE_RIGHT: f_used = 1'b0;
      default: r_used = 1'b0;
    endcase
  end

  logic [32:0] r_num, r_den, f_num, f_den;
  ramp_ctl_t   r_ctl, f_ctl;

  fme_ramp_setup u_rise (
    .clk(clk), .en(1'b1), .used(r_used), .rising(1'b1), .x(sample_value),
    .p(r_p), .q(r_q), .num(r_num), .den(r_den), .ctl(r_ctl)
  );
  fme_ramp_setup u_fall (
    .clk(clk), .en(1'b1), .used(f_used), .rising(1'b0), .x(sample_value),
    .p(f_p), .q(f_q), .num(f_num), .den(f_den), .ctl(f_ctl)
  );

  // make the divider operands safe when an early outcome holds
  logic [32:0] r_n_s, r_d_s, f_n_s, f_d_s;
  assign r_n_s = (r_ctl.zero || r_ctl.one) ? 33'd0 : r_num;
  assign r_d_s = (r_ctl.zero || r_ctl.one) ? 33'd1 : r_den;
  assign f_n_s = (f_ctl.zero || f_ctl.one) ? 33'd0 : f_num;
  assign f_d_s = (f_ctl.zero || f_ctl.one) ? 33'd1 : f_den;

  logic [OUT_FRAC_BITS-1:0] r_quo, f_quo;

  fme_div_pipe #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_r (
    .clk(clk), .en(1'b1), .num(r_n_s), .den(r_d_s), .quo(r_quo)
  );
  fme_div_pipe #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_f (
    .clk(clk), .en(1'b1), .num(f_n_s), .den(f_d_s), .quo(f_quo)
  );

  // control travels beside the divider
  ramp_ctl_t r_cpipe [STAGES+1];
  ramp_ctl_t f_cpipe [STAGES+1];
  assign r_cpipe[0] = r_ctl;
  assign f_cpipe[0] = f_ctl;
  for (genvar s = 0; s < STAGES; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      r_cpipe[s+1] <= r_cpipe[s];
      f_cpipe[s+1] <= f_cpipe[s];
    end
  end

  // resolve each ramp and combine with min
  logic [OUT_FRAC_BITS:0] r_val, f_val, m_val;
  ramp_ctl_t              rc, fc;
  always_comb begin
    rc = r_cpipe[STAGES];
    fc = f_cpipe[STAGES];
    if (rc.one) r_val = ONE_OUT;
    else if (rc.zero) r_val = '0;
    else r_val = {1'b0, r_quo};
    if (fc.one) f_val = ONE_OUT;
    else if (fc.zero) f_val = '0;
    else f_val = {1'b0, f_quo};
    if (!rc.used) m_val = f_val;
    else if (!fc.used) m_val = r_val;
    else m_val = (r_val < f_val) ? r_val : f_val;
  end

  // output register
  always_ff @(posedge clk) begin
    membership_degree <= m_val;
    degenerate_flag   <= rc.deg | fc.deg;
  end

  assign done = vld[DEPTH-1] && (InFracUnused >= 0);

endmodule

@@ rtl/fme_checker.sv @@
// checker: port-level properties of the fuzzy membership evaluator
module fme_checker #(
  parameter int OUT_FRAC_BITS = fme_pkg::OUT_FRAC_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [OUT_FRAC_BITS:0] membership_degree
);
  localparam logic [OUT_FRAC_BITS:0] ONE_OUT = {1'b1, {OUT_FRAC_BITS{1'b0}}};
  localparam int LAT = (OUT_FRAC_BITS + 3) / 4 + 2;

  // never refuses a sample
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

  // degree stays within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> membership_degree <= ONE_OUT)
    else $error("degree above one");

  // each accepted sample gives a result after fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("result missing");

  // no result without a sample
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("unexpected result");

endmodule

bind fuzzy_membership_evaluator fme_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_fme_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .membership_degree(membership_degree)
);

@@ tb/fuzzy_membership_evaluator_tb.sv @@
// testbench for the fuzzy membership evaluator: shape configs, directed and random samples

class membership_scoreboard;
  bit [15:0] degree_q[$];
  bit        flag_q[$];
  int        errors;

  // print one mismatch line and count it
  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  // remember the expected outcome of one accepted sample
  function void note_sample(bit [15:0] degree, bit flag);
    degree_q.push_back(degree);
    flag_q.push_back(flag);
  endfunction

  // compare one result beat against the oldest expectation
  task check_result(bit [15:0] degree, bit flag);
    bit [15:0] exp_degree;
    bit        exp_flag;
    if (degree_q.size() == 0) begin
      report($sformatf("result beat with nothing expected: degree %0d flag %0b",
                       degree, flag));
      return;
    end
    exp_degree = degree_q.pop_front();
    exp_flag = flag_q.pop_front();
    if (degree !== exp_degree) begin
      report($sformatf("membership_degree got %0d expected %0d", degree, exp_degree));
    end
    if (flag !== exp_flag) begin
      report($sformatf("degenerate_flag got %0b expected %0b", flag, exp_flag));
    end
  endtask
endclass

module fuzzy_membership_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fme_pkg::*;

  localparam int ONE_Q15   = 32768;
  localparam int WAIT_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic signed [31:0] sample_value = '0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        busy;
  logic        done;
  logic [15:0] membership_degree;
  logic        degenerate_flag;

  membership_scoreboard sb;
  int   idle_cycles;
  bit   quiet_stretch;

  // predictor copy of the configuration
  shape_t      cur_shape;
  logic signed [31:0] bp_a, bp_b, bp_c, bp_d;

  fuzzy_membership_evaluator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample_value(sample_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .membership_degree(membership_degree), .degenerate_flag(degenerate_flag)
  );

  always #6 clk = ~clk;

  // clamped quotient num/den in Q1.15, den nonzero
  function automatic longint clamp_ratio(longint num, longint den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 0;
    if (num >= den) return ONE_Q15;
    return (num << 15) / den;
  endfunction

  function automatic longint ramp_up(longint x, longint p, longint q, inout bit flag);
    if (p == q) begin
      flag = 1'b1;
      return (x >= p) ? ONE_Q15 : 0;
    end
    return clamp_ratio(x - p, q - p);
  endfunction

  function automatic longint ramp_down(longint x, longint p, longint q, inout bit flag);
    if (p == q) begin
      flag = 1'b1;
      return (x <= q) ? ONE_Q15 : 0;
    end
    return clamp_ratio(q - x, q - p);
  endfunction

  function automatic longint min_deg(longint u, longint v);
    return (u < v) ? u : v;
  endfunction

  // expected degree and flag for one sample under the current config
  task automatic predict_membership(logic signed [31:0] xs);
    longint x, a, b, c, d, m;
    bit flag;
    x = xs; a = bp_a; b = bp_b; c = bp_c; d = bp_d;
    flag = 1'b0;
    case (cur_shape)
      SHAPE_TRI:   m = min_deg(ramp_up(x, a, b, flag), ramp_down(x, b, c, flag));
      SHAPE_TRAP:  m = min_deg(ramp_up(x, a, b, flag), ramp_down(x, c, d, flag));
      SHAPE_RIGHT: m = ramp_up(x, a, b, flag);
      default:     m = ramp_down(x, a, b, flag);
    endcase
    sb.note_sample(m[15:0], flag);
  endtask

  // check every result beat
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(membership_degree, degenerate_flag);
  end

  // watchdog: cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WAIT_LIMIT) begin
      $display("fuzzy_membership_evaluator: mismatch");
      $finish;
    end
  end

  // one register write beat; the caller drops the write enable afterwards
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_SHAPE:   cur_shape = shape_t'(value[1:0]);
      REG_POINT_A: bp_a = value;
      REG_POINT_B: bp_b = value;
      REG_POINT_C: bp_c = value;
      REG_POINT_D: bp_d = value;
      default: ;
    endcase
  endtask

  task automatic write_shape(shape_t s, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d);
    write_reg(REG_SHAPE, 32'(s));
    write_reg(REG_POINT_A, a);
    write_reg(REG_POINT_B, b);
    write_reg(REG_POINT_C, c);
    write_reg(REG_POINT_D, d);
    cfg_we <= 1'b0;
  endtask

  // one sample beat, with random gaps before it outside quiet stretches
  task automatic send_sample(logic signed [31:0] x);
    while (!quiet_stretch && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    sample_value <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_membership(x);
  endtask

  task automatic end_burst();
    start <= 1'b0;
    while (sb.degree_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // random breakpoint near others, often equal, sometimes extreme
  function automatic logic [31:0] near_point(logic [31:0] base);
    case ($urandom_range(5))
      0: return base;
      1: return base + $urandom_range(8);
      2: return base + $urandom_range(1 << 20);
      3: return $urandom;
      4: return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return base - $urandom_range(1 << 18);
    endcase
  endfunction

  // samples spread over the breakpoints of interest
  function automatic logic [31:0] pick_sample();
    logic [31:0] pts[4];
    pts[0] = bp_a; pts[1] = bp_b; pts[2] = bp_c; pts[3] = bp_d;
    case ($urandom_range(4))
      0: return $urandom;
      1: return pts[$urandom_range(3)];
      2: return pts[$urandom_range(3)] + $urandom_range(4) - 2;
      default: return pts[$urandom_range(3)] + $urandom_range(1 << 21) - (1 << 20);
    endcase
  endfunction

  initial begin
    logic [31:0] pa, pb, pc, pd;
    sb = new();
    cur_shape = SHAPE_TRI;
    bp_a = 0; bp_b = 65536; bp_c = 131072; bp_d = 196608;
    quiet_stretch = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: triangle 0..1..2
    send_sample(32'sh0000_8000);
    send_sample(32'sh0001_0000);
    send_sample(32'sh0001_4000);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    end_burst();

    // every shape, extremes and equal breakpoints
    write_shape(SHAPE_TRAP, 32'h8000_0000, 32'h0, 32'h10, 32'h7fff_ffff);
    send_sample(32'sh8000_0000); send_sample(32'sh7fff_ffff); send_sample(32'sh8);
    send_sample(32'shc000_0000);
    end_burst();
    write_shape(SHAPE_RIGHT, 32'h100, 32'h100, 32'h0, 32'h0);
    send_sample(32'sh100); send_sample(32'shff); send_sample(32'sh8000_0000);
    end_burst();
    write_shape(SHAPE_LEFT, 32'h100, 32'h100, 32'h0, 32'h0);
    send_sample(32'sh100); send_sample(32'sh101); send_sample(32'sh7fff_ffff);
    end_burst();
    // reversed breakpoints, full-range differences
    write_shape(SHAPE_TRI, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
    send_sample(32'sh0); send_sample(32'sh8000_0000); send_sample(32'sh7fff_ffff);
    end_burst();
    write_shape(SHAPE_TRAP, 32'h5, 32'h5, 32'h9, 32'h9);
    send_sample(32'sh4); send_sample(32'sh5); send_sample(32'sh9); send_sample(32'sha);
    end_burst();
    // index past point_d is ignored by the block
    cfg_we <= 1'b1; cfg_index <= 3'd7; cfg_data <= 32'hffff_ffff;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_sample(32'sh7);
    end_burst();

    // random phases of fresh configurations
    for (int ph = 0; ph < 40; ph++) begin
      quiet_stretch = (ph % 7 == 3);
      pa = $urandom;
      if ($urandom_range(3) == 0) pa = pa >> $urandom_range(31);
      pb = near_point(pa); pc = near_point(pb); pd = near_point(pc);
      if (ph == 0) write_shape(SHAPE_TRI, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                               32'hffff_ffff);
      else write_shape(shape_t'($urandom_range(3)), pa, pb, pc, pd);
      for (int k = 0; k < 48; k++) send_sample(pick_sample());
      end_burst();
    end
    quiet_stretch = 1'b0;

    if (sb.errors == 0 && sb.degree_q.size() == 0) begin
      $display("fuzzy_membership_evaluator: match");
    end else begin
      $display("fuzzy_membership_evaluator: mismatch");
    end
    $finish;
  end
endmodule
